FILE: src/thermistor_adc_to_temperature_core_macros.svh
// Assertion macros for the thermistor conversion checker.
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_CORE_MACROS_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define TATC_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tatc: invariant violated");

// Antecedent at an edge implies the consequent at the same edge.
`define TATC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tatc: implication violated");

`endif

FILE: src/tatc_pkg.sv
// Types, constants and calibration table for the thermistor conversion core.
`timescale 1ns / 1ps

package tatc_pkg;

  localparam int ADC_W        = 12;
  localparam int CODE_W       = 10;
  localparam int TEMP_W       = 12;
  localparam int ROM_SLOTS    = 64;
  localparam int IDX_W        = $clog2(ROM_SLOTS);
  localparam int FRAC_W       = 6;
  localparam int NUM_W        = 16;
  localparam int START_TENTHS = -200;
  localparam int END_TENTHS   = 1200;
  localparam int STEP_TENTHS  = 50;
  localparam int FIRST_CODE   = 892;
  localparam int DIV_STAGES   = 3;
  localparam int BITS_PER_DIV = FRAC_W / DIV_STAGES;
  // compare, group count, total, lookup, three divide stages, output
  localparam int PIPE_LATENCY = 8;

  typedef logic [CODE_W-1:0] code_t;

  // One slot of the restoring divider pipeline.
  typedef struct packed {
    logic              valid;
    logic              ge_first;
    logic              le_last;
    logic [IDX_W-1:0]  above;
    logic [NUM_W-1:0]  rem;
    logic [CODE_W-1:0] den;
    logic [FRAC_W-1:0] quo;
  } div_slot_t;

  // Calibration codes, one per 5 degrees from -20 C; unused slots read zero.
  function automatic code_t rom_at(input logic [IDX_W-1:0] idx);
    code_t c;
    case (idx)
      6'd0:    c = 10'd892;
      6'd1:    c = 10'd863;
      6'd2:    c = 10'd829;
      6'd3:    c = 10'd791;
      6'd4:    c = 10'd749;
      6'd5:    c = 10'd705;
      6'd6:    c = 10'd657;
      6'd7:    c = 10'd609;
      6'd8:    c = 10'd560;
      6'd9:    c = 10'd512;
      6'd10:   c = 10'd465;
      6'd11:   c = 10'd420;
      6'd12:   c = 10'd377;
      6'd13:   c = 10'd337;
      6'd14:   c = 10'd300;
      6'd15:   c = 10'd267;
      6'd16:   c = 10'd238;
      6'd17:   c = 10'd211;
      6'd18:   c = 10'd187;
      6'd19:   c = 10'd166;
      6'd20:   c = 10'd146;
      6'd21:   c = 10'd130;
      6'd22:   c = 10'd115;
      6'd23:   c = 10'd102;
      6'd24:   c = 10'd91;
      6'd25:   c = 10'd81;
      6'd26:   c = 10'd72;
      6'd27:   c = 10'd65;
      6'd28:   c = 10'd58;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: src/thermistor_adc_to_temperature_core.sv
// Each transaction accepted at an edge gives one done strobe from the output stage.
// Throughput: one sample per cycle; busy stays low, so start may be held high.
// Latency is set by the 8-stage pipeline: compare, group count, total,
// table lookup, three 2-bit restoring divide stages and the output stage.
// Reset: synchronous, clears every valid bit and done; data registers are not reset.
`timescale 1ns / 1ps

module thermistor_adc_to_temperature_core #(
  parameter int TABLE_ENTRIES = 29
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tatc_pkg::ADC_W-1:0]           adc_raw,
  output logic                                 done,
  output logic signed [tatc_pkg::TEMP_W-1:0]   temperature_tenths
);

  localparam int IDX_W  = tatc_pkg::IDX_W;
  localparam int CODE_W = tatc_pkg::CODE_W;
  localparam int NUM_W  = tatc_pkg::NUM_W;
  localparam int FRAC_W = tatc_pkg::FRAC_W;
  localparam int GROUPS = (TABLE_ENTRIES + 7) / 8;
  localparam int PAD_W  = GROUPS * 8;
  localparam int GRP_W  = 4;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int TW     = tatc_pkg::TEMP_W + 1;
  localparam int NDIV   = tatc_pkg::DIV_STAGES;
  localparam int BPD    = tatc_pkg::BITS_PER_DIV;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic signed [TW-1:0] T_MIN = TW'(tatc_pkg::START_TENTHS);
  localparam logic signed [TW-1:0] T_MAX = TW'(tatc_pkg::END_TENTHS);

  assign busy = 1'b0;

  // Stage 1: compare the code with every table entry in use.
  logic                      s1_valid;
  logic [CODE_W-1:0]         s1_code;
  logic [PAD_W-1:0]          s1_gt;
  logic                      s1_ge_first;
  logic                      s1_le_last;
  logic [CODE_W-1:0]         code_in;
  logic [PAD_W-1:0]          gt_next;

  assign code_in = adc_raw[tatc_pkg::ADC_W-1:2];

  always_comb begin
    gt_next = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      gt_next[i] = code_in < tatc_pkg::rom_at(IDX_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_code     <= code_in;
    s1_gt       <= gt_next;
    s1_ge_first <= code_in >= tatc_pkg::rom_at('0);
    s1_le_last  <= code_in <= tatc_pkg::rom_at(LAST_IDX);
  end

  // Stage 2: count entries above the code in groups of eight.
  logic                      s2_valid;
  logic [CODE_W-1:0]         s2_code;
  logic                      s2_ge_first;
  logic                      s2_le_last;
  logic [GRP_W-1:0]          s2_grp [GROUPS];
  logic [GRP_W-1:0]          grp_next [GROUPS];

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_next[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_next[g] = grp_next[g] + GRP_W'(s1_gt[g*8 + b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_code     <= s1_code;
    s2_ge_first <= s1_ge_first;
    s2_le_last  <= s1_le_last;
    s2_grp      <= grp_next;
  end

  // Stage 3: total the groups and hold the segment index inside the table.
  logic                      s3_valid;
  logic [CODE_W-1:0]         s3_code;
  logic                      s3_ge_first;
  logic                      s3_le_last;
  logic [IDX_W-1:0]          s3_above;
  logic [CNT_W-1:0]          cnt_sum;
  logic [CNT_W-1:0]          cnt_clamped;

  always_comb begin
    cnt_sum = '0;
    for (int g = 0; g < GROUPS; g++) begin
      cnt_sum = cnt_sum + CNT_W'(s2_grp[g]);
    end
    cnt_clamped = cnt_sum;
    if (cnt_clamped < CNT_W'(1)) begin
      cnt_clamped = CNT_W'(1);
    end
    if (cnt_clamped > LAST_CNT) begin
      cnt_clamped = LAST_CNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_code     <= s2_code;
    s3_ge_first <= s2_ge_first;
    s3_le_last  <= s2_le_last;
    s3_above    <= IDX_W'(cnt_clamped);
  end

  // Stage 4: fetch neighbouring entries and form dividend and divisor.
  // Stages 5 to 7: restoring division, two quotient bits per stage.
  tatc_pkg::div_slot_t dv      [NDIV+1];
  tatc_pkg::div_slot_t dv_next [NDIV+1];
  logic [CODE_W-1:0]   hi_code;
  logic [CODE_W-1:0]   lo_code;
  logic                seg_ok;
  logic [NUM_W-1:0]    trial;

  always_comb begin
    hi_code = tatc_pkg::rom_at(s3_above - IDX_W'(1));
    lo_code = tatc_pkg::rom_at(s3_above);
    seg_ok  = (hi_code > lo_code) && (s3_code >= lo_code);
    trial   = '0;
    // drop in-flight transactions while in reset
    dv_next[0].valid    = s3_valid && !rst;
    dv_next[0].ge_first = s3_ge_first;
    dv_next[0].le_last  = s3_le_last;
    dv_next[0].above    = s3_above;
    dv_next[0].quo      = '0;
    if (seg_ok) begin
      dv_next[0].rem = NUM_W'(s3_code - lo_code) * NUM_W'(tatc_pkg::STEP_TENTHS);
      dv_next[0].den = hi_code - lo_code;
    end else begin
      // flat step or code below the lower entry: zero dividend over a non-zero divisor yields a zero fraction
      dv_next[0].rem = '0;
      dv_next[0].den = '1;
    end
    for (int s = 0; s < NDIV; s++) begin
      dv_next[s+1]       = dv[s];
      dv_next[s+1].valid = dv[s].valid && !rst;
      for (int j = 0; j < BPD; j++) begin
        trial = NUM_W'(dv[s].den) << (FRAC_W - 1 - s*BPD - j);
        if (dv_next[s+1].rem >= trial) begin
          dv_next[s+1].rem = dv_next[s+1].rem - trial;
          dv_next[s+1].quo[FRAC_W - 1 - s*BPD - j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dv <= dv_next;
  end

  // Stage 8: interpolate, clamp and present the result.
  logic [TW-1:0]        base_prod;
  logic signed [TW-1:0] temp_raw;
  logic signed [TW-1:0] temp_sel;

  always_comb begin
    base_prod = TW'(dv[NDIV].above) * TW'(tatc_pkg::STEP_TENTHS);
    temp_raw  = $signed(base_prod) + T_MIN - $signed(TW'(dv[NDIV].quo));
    if (dv[NDIV].ge_first) begin
      temp_sel = T_MIN;
    end else if (dv[NDIV].le_last) begin
      temp_sel = T_MAX;
    end else if (temp_raw < T_MIN) begin
      temp_sel = T_MIN;
    end else if (temp_raw > T_MAX) begin
      temp_sel = T_MAX;
    end else begin
      temp_sel = temp_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[NDIV].valid;
    end
    temperature_tenths <= temp_sel[tatc_pkg::TEMP_W-1:0];
  end

endmodule

FILE: src/tatc_checker.sv
// Port-level checker for the thermistor conversion core, bound to the top level.
`timescale 1ns / 1ps
`include "thermistor_adc_to_temperature_core_macros.svh"

module tatc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic [tatc_pkg::ADC_W-1:0]          adc_raw,
  input logic                                done,
  input logic signed [tatc_pkg::TEMP_W-1:0]  temperature_tenths
);

  // every transaction comes out after the fixed pipeline latency
  `TATC_ASSERT_IMPLIES(a_done_has_source, clk, rst, done, $past(start && !busy, tatc_pkg::PIPE_LATENCY))

  `TATC_ASSERT_IMPLIES(a_start_gives_done, clk, rst, start && !busy, ##(tatc_pkg::PIPE_LATENCY) done)

  // results stay within the calibrated span
  `TATC_ASSERT_IMPLIES(a_range, clk, rst, done, ($signed(temperature_tenths) >= $signed(12'(tatc_pkg::START_TENTHS))) && ($signed(temperature_tenths) <= $signed(12'(tatc_pkg::END_TENTHS))))

  // codes at or above the first entry read as the cold limit
  `TATC_ASSERT_IMPLIES(a_cold_clamp, clk, rst, done && ($past(adc_raw[tatc_pkg::ADC_W-1:2], tatc_pkg::PIPE_LATENCY) >= 10'(tatc_pkg::FIRST_CODE)), temperature_tenths == 12'(tatc_pkg::START_TENTHS))

endmodule

bind thermistor_adc_to_temperature_core tatc_checker u_tatc_checker (
  .clk                (clk),
  .rst                (rst),
  .start              (start),
  .busy               (busy),
  .adc_raw            (adc_raw),
  .done               (done),
  .temperature_tenths (temperature_tenths)
);
